FILE: src/tpd_pkg.sv
// shared constants, register codes and helpers for the temporal pixel denoiser
package tpd_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TOTAL_W    = ADDR_W + 1;

	localparam int DIM_W   = 11;
	localparam int COEF_W  = 9;
	localparam int THR_W   = 24;
	localparam int PIX_W   = 8;
	localparam int MEAN_W  = 16;
	localparam int M2_W    = 24;
	localparam int CNT_W   = 21;
	localparam int MEM_W   = MEAN_W + M2_W;
	localparam int CFG_W   = 24;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEF     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NOISE_THRESHOLD = 3'd3;

	localparam logic [DIM_W-1:0]  RST_WIDTH  = 11'd1024;
	localparam logic [DIM_W-1:0]  RST_HEIGHT = 11'd720;
	localparam logic [COEF_W-1:0] RST_COEF   = 9'd179;
	localparam logic [THR_W-1:0]  RST_THR    = 24'd19200;
	localparam logic [COEF_W-1:0] COEF_ONE   = 9'd256;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int hi);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) r = DIM_W'(1);
		else if (int'(v) > hi) r = DIM_W'(hi);
		return r;
	endfunction

	function automatic logic [TOTAL_W-1:0] frame_pixels(input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h);
		logic [2*DIM_W-1:0] p;
		p = (2*DIM_W)'(clamp_dim(w, MAX_WIDTH)) * (2*DIM_W)'(clamp_dim(h, MAX_HEIGHT));
		return TOTAL_W'(p);
	endfunction

endpackage

FILE: src/temporal_pixel_denoiser.sv
// temporal pixel denoiser: per-pixel recursive mean and second moment in one memory
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  input   | in_valid / in_stall    | pixel_in
//  output  | out_valid / out_stall  | pixel_out, replaced, frame_end, changed_count
//  config  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one item per cycle sustained while the output does not stall;
// the read/modify/write of the moment memory sets that rate
// memory read at accept; s1 filter update and write back, s2 squares, s3 decision, s4 output
// no clearing pass: a fill count marks which entries were written since reset or resize
// a stalled output holds s4 and back-pressure travels upstream only through full stages
module temporal_pixel_denoiser (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [tpd_pkg::PIX_W-1:0]        pixel_in,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [tpd_pkg::PIX_W-1:0]        pixel_out,
	output logic                             replaced,
	output logic                             frame_end,
	output logic [tpd_pkg::CNT_W-1:0]        changed_count,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tpd_pkg::CFG_W-1:0]        cfg_data
);

	// configuration
	logic [tpd_pkg::DIM_W-1:0]   width_q, height_q;
	logic [tpd_pkg::COEF_W-1:0]  coef_q;
	logic [tpd_pkg::THR_W-1:0]   thr_q;
	logic [tpd_pkg::TOTAL_W-1:0] total_q;
	logic [tpd_pkg::TOTAL_W-1:0] cfg_total;
	logic                        cfg_wr;

	// position and fill state
	logic [tpd_pkg::ADDR_W-1:0]  pos_q;
	logic [tpd_pkg::TOTAL_W-1:0] fill_q;
	logic [tpd_pkg::CNT_W-1:0]   tally_q;

	logic in_acc, last_s0;
	logic en1, en2, en3, en4;
	logic v1, v2, v3, v4;

	// memory
	logic [tpd_pkg::MEM_W-1:0]   mem [tpd_pkg::DEPTH];
	logic [tpd_pkg::MEM_W-1:0]   rd_data_s1;
	logic                        wr_en;

	// stage 1
	logic [tpd_pkg::PIX_W-1:0]   pix_s1;
	logic [2*tpd_pkg::PIX_W-1:0] pixsq_s1;
	logic [tpd_pkg::ADDR_W-1:0]  pos_s1;
	logic                        last_s1;

	// stage 2
	logic [tpd_pkg::PIX_W-1:0]   pix_s2;
	logic [tpd_pkg::ADDR_W-1:0]  pos_s2;
	logic                        last_s2;
	logic [tpd_pkg::MEAN_W-1:0]  m1_s2;
	logic [tpd_pkg::M2_W-1:0]    m2_s2;

	// stage 3
	logic [tpd_pkg::PIX_W-1:0]   pix_s3;
	logic                        last_s3;
	logic [tpd_pkg::PIX_W-1:0]   mhi_s3;
	logic [tpd_pkg::M2_W-1:0]    m2_s3;
	logic [23:0]                 m1sq_s3;
	logic [24:0]                 dev2_s3;

	// stage 4 (output register)
	logic [tpd_pkg::PIX_W-1:0]   pix_s4;
	logic                        rep_s4, last_s4;
	logic [tpd_pkg::CNT_W-1:0]   cnt_s4;

	// combinational
	logic [tpd_pkg::COEF_W-1:0]  coef_c, coef_nc;
	logic                        fwd, mem_ok;
	logic [tpd_pkg::MEAN_W-1:0]  old_mean, m1_new;
	logic [tpd_pkg::M2_W-1:0]    old_m2, m2_new;
	logic [25:0]                 m1_sum;
	logic [33:0]                 m2_sum;
	logic [31:0]                 m1sq;
	logic signed [16:0]          dev;
	logic signed [33:0]          devsq;
	logic signed [25:0]          var_s3;
	logic                        rep3;
	logic [tpd_pkg::CNT_W-1:0]   tally_next;

	function automatic logic [tpd_pkg::TOTAL_W-1:0] TOTAL_W_ADD(
			input logic [tpd_pkg::ADDR_W-1:0] p);
		return {1'b0, p} + tpd_pkg::TOTAL_W'(1);
	endfunction

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		cfg_total = total_q;
		unique case (cfg_index)
			tpd_pkg::REG_FRAME_WIDTH:
				cfg_total = tpd_pkg::frame_pixels(cfg_data[tpd_pkg::DIM_W-1:0], height_q);
			tpd_pkg::REG_FRAME_HEIGHT:
				cfg_total = tpd_pkg::frame_pixels(width_q, cfg_data[tpd_pkg::DIM_W-1:0]);
			default: cfg_total = total_q;
		endcase
	end

	// stage enables: a stage moves when it is empty or the next one moves
	assign en4      = !v4 || !out_stall;
	assign en3      = !v3 || en4;
	assign en2      = !v2 || en3;
	assign en1      = !v1 || en2;
	assign in_stall = !en1;
	assign in_acc   = in_valid && en1;
	assign wr_en    = v1 && en2;

	assign last_s0 = (TOTAL_W_ADD(pos_q) >= total_q);

	// config registers and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tpd_pkg::RST_WIDTH;
			height_q <= tpd_pkg::RST_HEIGHT;
			coef_q   <= tpd_pkg::RST_COEF;
			thr_q    <= tpd_pkg::RST_THR;
			total_q  <= tpd_pkg::frame_pixels(tpd_pkg::RST_WIDTH, tpd_pkg::RST_HEIGHT);
			pos_q    <= '0;
			fill_q   <= '0;
			tally_q  <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					tpd_pkg::REG_FRAME_WIDTH:     width_q  <= cfg_data[tpd_pkg::DIM_W-1:0];
					tpd_pkg::REG_FRAME_HEIGHT:    height_q <= cfg_data[tpd_pkg::DIM_W-1:0];
					tpd_pkg::REG_FILTER_COEF:     coef_q   <= cfg_data[tpd_pkg::COEF_W-1:0];
					tpd_pkg::REG_NOISE_THRESHOLD: thr_q    <= cfg_data[tpd_pkg::THR_W-1:0];
					default: ;
				endcase
				// a new frame size starts over with empty moments
				if (cfg_total != total_q) begin
					total_q <= cfg_total;
					pos_q   <= '0;
					fill_q  <= '0;
					tally_q <= '0;
				end
			end
			if (in_acc) begin
				if (last_s0) pos_q <= '0;
				else pos_q <= pos_q + tpd_pkg::ADDR_W'(1);
			end
			if (wr_en && ({1'b0, pos_s1} == fill_q)) begin
				fill_q <= fill_q + tpd_pkg::TOTAL_W'(1);
			end
			if (v3 && en4) begin
				if (last_s3) tally_q <= '0;
				else tally_q <= tally_next;
			end
		end
	end

	// moment memory: one read port at accept, one write port at s1 exit
	always_ff @(posedge clk) begin
		if (in_acc) rd_data_s1 <= mem[pos_q];
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[pos_s1] <= {m1_new, m2_new};
	end

	// stage 1: filter update, entry just written and held in s2 is forwarded
	always_comb begin
		coef_c   = (coef_q > tpd_pkg::COEF_ONE) ? tpd_pkg::COEF_ONE : coef_q;
		coef_nc  = tpd_pkg::COEF_W'(10'd256 - {1'b0, coef_c});
		fwd      = v2 && (pos_s2 == pos_s1);
		mem_ok   = ({1'b0, pos_s1} < fill_q);
		old_mean = '0;
		old_m2   = '0;
		if (fwd) begin
			old_mean = m1_s2;
			old_m2   = m2_s2;
		end else if (mem_ok) begin
			old_mean = rd_data_s1[tpd_pkg::MEM_W-1:tpd_pkg::M2_W];
			old_m2   = rd_data_s1[tpd_pkg::M2_W-1:0];
		end
		m1_sum = 26'(old_mean) * 26'(coef_c) + ((26'(coef_nc) * 26'(pix_s1)) << 8);
		m2_sum = 34'(old_m2) * 34'(coef_c) + ((34'(coef_nc) * 34'(pixsq_s1)) << 8);
		m1_new = m1_sum[23:8];
		m2_new = m2_sum[31:8];
	end

	// stage 2: squares of mean and deviation
	always_comb begin
		m1sq  = 32'(m1_s2) * 32'(m1_s2);
		dev   = $signed({1'b0, pix_s2, 8'b0}) - $signed({1'b0, m1_s2});
		devsq = 34'(dev) * 34'(dev);
	end

	// stage 3: decision, negative variance passes
	always_comb begin
		var_s3     = $signed({2'b0, m2_s3}) - $signed({2'b0, m1sq_s3});
		rep3       = (var_s3 < $signed({2'b0, thr_q})) && (dev2_s3 < {1'b0, thr_q});
		tally_next = tally_q + tpd_pkg::CNT_W'(rep3);
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
		end else begin
			if (en1) v1 <= in_valid;
			if (en2) v2 <= v1;
			if (en3) v3 <= v2;
			if (en4) v4 <= v3;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1   <= pixel_in;
			pixsq_s1 <= (2*tpd_pkg::PIX_W)'(pixel_in) * (2*tpd_pkg::PIX_W)'(pixel_in);
			pos_s1   <= pos_q;
			last_s1  <= last_s0;
		end
		if (wr_en) begin
			pix_s2  <= pix_s1;
			pos_s2  <= pos_s1;
			last_s2 <= last_s1;
			m1_s2   <= m1_new;
			m2_s2   <= m2_new;
		end
		if (v2 && en3) begin
			pix_s3  <= pix_s2;
			last_s3 <= last_s2;
			mhi_s3  <= m1_s2[tpd_pkg::MEAN_W-1:tpd_pkg::MEAN_W-tpd_pkg::PIX_W];
			m2_s3   <= m2_s2;
			m1sq_s3 <= m1sq[31:8];
			dev2_s3 <= devsq[32:8];
		end
		if (v3 && en4) begin
			pix_s4  <= rep3 ? mhi_s3 : pix_s3;
			rep_s4  <= rep3;
			last_s4 <= last_s3;
			cnt_s4  <= last_s3 ? tally_next : '0;
		end
	end

	assign out_valid     = v4;
	assign pixel_out     = pix_s4;
	assign replaced      = rep_s4;
	assign frame_end     = last_s4;
	assign changed_count = cnt_s4;

	// the fill count never runs past the frame
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= total_q)
		else $error("fill count beyond frame size");

	// position stays inside the frame
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} < total_q)
		else $error("pixel position outside frame");

	// end of frame wraps the position
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_s0 && !cfg_wr |=> pos_q == '0)
		else $error("position did not wrap at frame end");

	// back-to-back hits on one entry only happen for a one-pixel frame
	a_fwd_only_single: assert property (@(posedge clk) disable iff (!arst_n)
		v1 && v2 && (pos_s1 == pos_s2) |-> total_q == tpd_pkg::TOTAL_W'(1))
		else $error("unexpected same-entry overlap");

	// the count is only reported at frame end
	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_end |-> changed_count == '0)
		else $error("count reported off frame end");

endmodule

FILE: dv/temporal_pixel_denoiser_tb.sv
// self-checking testbench for the temporal pixel denoiser with a per-pixel moment predictor
`timescale 1ns / 100ps

typedef struct packed {
	logic [tpd_pkg::PIX_W-1:0] pixel;
	logic                      replaced;
	logic                      frame_end;
	logic [tpd_pkg::CNT_W-1:0] count;
} denoise_result_t;

class denoise_scoreboard;
	logic [tpd_pkg::DIM_W-1:0]  width_reg;
	logic [tpd_pkg::DIM_W-1:0]  height_reg;
	logic [tpd_pkg::COEF_W-1:0] coef_reg;
	logic [tpd_pkg::THR_W-1:0]  thr_reg;
	// sparse copies of the moment memories, missing entries read as zero
	logic [tpd_pkg::MEAN_W-1:0] mean_mem [int unsigned];
	logic [tpd_pkg::M2_W-1:0]   moment_mem [int unsigned];
	int unsigned                position;
	logic [tpd_pkg::CNT_W-1:0]  tally;
	denoise_result_t            expected_q [$];
	int errors;
	int checked;
	int frame_ends;
	int replaced_seen;

	function new();
		width_reg  = tpd_pkg::RST_WIDTH;
		height_reg = tpd_pkg::RST_HEIGHT;
		coef_reg   = tpd_pkg::RST_COEF;
		thr_reg    = tpd_pkg::RST_THR;
		errors = 0;
		checked = 0;
		frame_ends = 0;
		replaced_seen = 0;
		clear_moments();
	endfunction

	function void clear_moments();
		mean_mem.delete();
		moment_mem.delete();
		position = 0;
		tally = '0;
	endfunction

	function int unsigned eff_dim(logic [tpd_pkg::DIM_W-1:0] v, int unsigned hi);
		if (v == '0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function int unsigned frame_size();
		return eff_dim(width_reg, tpd_pkg::MAX_WIDTH) * eff_dim(height_reg, tpd_pkg::MAX_HEIGHT);
	endfunction

	function void write_reg(logic [tpd_pkg::CFG_IDX_W-1:0] idx, logic [tpd_pkg::CFG_W-1:0] data);
		int unsigned old_size;
		old_size = frame_size();
		case (idx)
			tpd_pkg::REG_FRAME_WIDTH:     width_reg = data[tpd_pkg::DIM_W-1:0];
			tpd_pkg::REG_FRAME_HEIGHT:    height_reg = data[tpd_pkg::DIM_W-1:0];
			tpd_pkg::REG_FILTER_COEF:     coef_reg = data[tpd_pkg::COEF_W-1:0];
			tpd_pkg::REG_NOISE_THRESHOLD: thr_reg = data[tpd_pkg::THR_W-1:0];
			default: ;
		endcase
		// only a real change of pixel count wipes the history
		if (frame_size() != old_size)
			clear_moments();
	endfunction

	function void take_pixel(logic [tpd_pkg::PIX_W-1:0] pix);
		longint unsigned c, nc, p, old_mean, old_m2, m1, m2;
		longint          variance, dev, dev2;
		int unsigned     total, pos;
		bit              rep, last;
		denoise_result_t r;
		c = (coef_reg > tpd_pkg::COEF_ONE) ? 256 : coef_reg;
		nc = 256 - c;
		p = pix;
		total = frame_size();
		pos = (position >= total) ? 0 : position;
		old_mean = mean_mem.exists(pos) ? mean_mem[pos] : 0;
		old_m2 = moment_mem.exists(pos) ? moment_mem[pos] : 0;
		m1 = ((old_mean * c + ((nc * p) << 8)) >> 8) & 64'hFFFF;
		m2 = ((old_m2 * c + ((nc * p * p) << 8)) >> 8) & 64'hFF_FFFF;
		mean_mem[pos] = m1[tpd_pkg::MEAN_W-1:0];
		moment_mem[pos] = m2[tpd_pkg::M2_W-1:0];
		// rounding can push the variance below zero, compared signed
		variance = longint'(m2) - longint'((m1 * m1) >> 8);
		dev = longint'(p << 8) - longint'(m1);
		dev2 = longint'(longint'(unsigned'(dev * dev)) >> 8);
		rep = (variance < longint'(thr_reg)) && (dev2 < longint'(thr_reg));
		if (rep)
			tally = tally + 1'b1;
		last = (pos + 1 >= total);
		r.pixel = rep ? m1[15:8] : pix;
		r.replaced = rep;
		r.frame_end = last;
		r.count = last ? tally : '0;
		expected_q.push_back(r);
		if (last) begin
			position = 0;
			tally = '0;
		end else begin
			position = pos + 1;
		end
	endfunction

	task report_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	task check_output(denoise_result_t got);
		denoise_result_t want;
		checked++;
		if (got.frame_end === 1'b1) frame_ends++;
		if (got.replaced === 1'b1) replaced_seen++;
		if (expected_q.size() == 0) begin
			report_mismatch("output item with nothing expected");
			return;
		end
		want = expected_q.pop_front();
		if (got.pixel !== want.pixel)
			report_mismatch($sformatf("pixel_out %0h, expected %0h", got.pixel, want.pixel));
		if (got.replaced !== want.replaced)
			report_mismatch($sformatf("replaced %b, expected %b", got.replaced, want.replaced));
		if (got.frame_end !== want.frame_end)
			report_mismatch($sformatf("frame_end %b, expected %b", got.frame_end, want.frame_end));
		if (got.count !== want.count)
			report_mismatch($sformatf("changed_count %0d, expected %0d", got.count, want.count));
	endtask

	function int pending();
		return expected_q.size();
	endfunction
endclass

module temporal_pixel_denoiser_tb;
	localparam logic [tpd_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd5;
	localparam logic [tpd_pkg::THR_W-1:0] THR_MAX = '1;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [tpd_pkg::PIX_W-1:0]     pixel_in = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [tpd_pkg::PIX_W-1:0]     pixel_out;
	logic                          replaced;
	logic                          frame_end;
	logic [tpd_pkg::CNT_W-1:0]     changed_count;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [tpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [tpd_pkg::CFG_W-1:0]     cfg_data = '0;

	denoise_scoreboard board;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int pixels_sent = 0;
	int cfg_writes = 0;

	temporal_pixel_denoiser u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_in(pixel_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_out(pixel_out),
		.replaced(replaced),
		.frame_end(frame_end),
		.changed_count(changed_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: a long hold-off when requested, random stalls otherwise
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			board.check_output(denoise_result_t'({pixel_out, replaced, frame_end, changed_count}));
	end

	task wait_drained();
		@(negedge clk) in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task cfg_write(logic [tpd_pkg::CFG_IDX_W-1:0] idx, logic [tpd_pkg::CFG_W-1:0] data);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		board.write_reg(idx, data);
		cfg_writes++;
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task send_pixel(logic [tpd_pkg::PIX_W-1:0] pix);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= pix;
		do @(posedge clk); while (in_stall !== 1'b0);
		board.take_pixel(pix);
		pixels_sent++;
	endtask

	// mostly a steady scene with small noise, sometimes arbitrary values
	function automatic logic [tpd_pkg::PIX_W-1:0] noisy_pixel(int base);
		int v;
		if ($urandom_range(0, 9) < 7) begin
			v = base + int'($urandom_range(0, 8)) - 4;
			if (v < 0) v = 0;
			if (v > 255) v = 255;
		end else begin
			v = $urandom_range(0, 255);
		end
		return v[tpd_pkg::PIX_W-1:0];
	endfunction

	function automatic int pick_dim();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return $urandom_range(1025, 2047);
			2: return $urandom_range(1, 1024);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	task pick_setting();
		logic [tpd_pkg::CFG_W-1:0] junk;
		int coef;
		int thr;
		// upper bits beyond each register's width are noise half the time
		junk = $urandom_range(0, 1) ? tpd_pkg::CFG_W'($urandom) : '0;
		cfg_write(tpd_pkg::REG_FRAME_WIDTH, (junk & 24'hFFF800) | tpd_pkg::CFG_W'(pick_dim()));
		cfg_write(tpd_pkg::REG_FRAME_HEIGHT, (junk & 24'hFFF800) | tpd_pkg::CFG_W'(pick_dim()));
		case ($urandom_range(0, 5))
			0: coef = 0;
			1: coef = 256;
			2: coef = $urandom_range(257, 511);
			default: coef = $urandom_range(0, 256);
		endcase
		cfg_write(tpd_pkg::REG_FILTER_COEF, (junk & 24'hFFFE00) | tpd_pkg::CFG_W'(coef));
		case ($urandom_range(0, 5))
			0: thr = 0;
			1: thr = THR_MAX;
			2: thr = $urandom_range(0, THR_MAX);
			default: thr = $urandom_range(0, 40000);
		endcase
		cfg_write(tpd_pkg::REG_NOISE_THRESHOLD, tpd_pkg::CFG_W'(thr));
	endtask

	initial begin
		#3_000_000;
		$display("timeout with %0d output items outstanding", board.pending());
		$display("temporal_pixel_denoiser test failed");
		$finish;
	end

	initial begin
		int phase;
		int n;
		int base;
		board = new();
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// reset settings, fresh history
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'h55);
		send_pixel(8'hAA);
		// one-pixel frame: every item ends a frame
		cfg_write(tpd_pkg::REG_FRAME_WIDTH, 24'd1);
		cfg_write(tpd_pkg::REG_FRAME_HEIGHT, 24'd1);
		cfg_write(tpd_pkg::REG_FILTER_COEF, 24'd0);
		cfg_write(tpd_pkg::REG_NOISE_THRESHOLD, THR_MAX);
		send_pixel(8'd200);
		send_pixel(8'd200);
		// zero threshold rejects everything
		cfg_write(tpd_pkg::REG_NOISE_THRESHOLD, 24'd0);
		send_pixel(8'd17);
		// full weight on history, new sample ignored
		cfg_write(tpd_pkg::REG_FILTER_COEF, tpd_pkg::CFG_W'(tpd_pkg::COEF_ONE));
		cfg_write(tpd_pkg::REG_NOISE_THRESHOLD, tpd_pkg::RST_THR);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		// coefficient above one saturates
		cfg_write(tpd_pkg::REG_FILTER_COEF, 24'h1FF);
		send_pixel(8'd9);
		// zero width maps to one, same size keeps the history
		cfg_write(tpd_pkg::REG_FRAME_WIDTH, 24'd0);
		send_pixel(8'd100);
		// oversize dimensions saturate to the maximum frame
		cfg_write(tpd_pkg::REG_FILTER_COEF, tpd_pkg::CFG_W'(tpd_pkg::RST_COEF));
		cfg_write(tpd_pkg::REG_FRAME_WIDTH, 24'h7FF);
		cfg_write(tpd_pkg::REG_FRAME_HEIGHT, 24'h7FF);
		send_pixel(8'hFF);
		send_pixel(8'h00);
		// small frame, width written with junk above the field
		cfg_write(tpd_pkg::REG_FRAME_WIDTH, 24'hFFF803);
		cfg_write(tpd_pkg::REG_FRAME_HEIGHT, 24'd2);
		for (int i = 0; i < 12; i++)
			send_pixel((i % 3 == 2) ? 8'd255 : 8'd120 + 8'(i % 2));
		cfg_write(REG_SPARE, 24'hABCDEF);

		for (phase = 0; pixels_sent < 625; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
				default: begin send_idle_pct = 17; recv_stall_pct = 17; end
			endcase
			pick_setting();
			base = $urandom_range(0, 255);
			n = $urandom_range(20, 56);
			if (phase == 4) begin
				// output held off while the input keeps offering items
				n = 40;
				hold_left = HOLD_CYCLES;
			end
			for (int i = 0; i < n; i++) begin
				send_pixel(noisy_pixel(base));
				if (phase == 6 && i == n / 2)
					wait_drained();
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("%0d pixels over %0d register writes; %0d outputs checked",
			pixels_sent, cfg_writes, board.checked);
		$display("%0d frame ends and %0d replaced pixels observed",
			board.frame_ends, board.replaced_seen);
		if (board.errors == 0 && board.pending() == 0)
			$display("temporal_pixel_denoiser test passed");
		else
			$display("temporal_pixel_denoiser test failed");
		$finish;
	end
endmodule

FILE: temporal_pixel_denoiser.f
src/tpd_pkg.sv
src/temporal_pixel_denoiser.sv
dv/temporal_pixel_denoiser_tb.sv
